FILE: rtl/rgb_to_yuv420_block_unit_assert.svh
// Assertion macros for the RGB to YUV 4:2:0 block unit.
// Depends on nothing; included inside module bodies.
`ifndef RGB_TO_YUV420_BLOCK_UNIT_ASSERT_SVH
`define RGB_TO_YUV420_BLOCK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RYUV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ryuv assertion failed");

// Next-cycle implication, disabled during reset.
`define RYUV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ryuv assertion failed");

`endif

FILE: rtl/ryuv_pkg.sv
// Types and coefficients for the RGB to YUV 4:2:0 block unit.
// No dependencies.
package ryuv_pkg;

  typedef logic [23:0] pixel_t;
  typedef logic [7:0]  sample_t;

  typedef struct packed {
    pixel_t pixel_top_left;
    pixel_t pixel_top_right;
    pixel_t pixel_bottom_left;
    pixel_t pixel_bottom_right;
    logic   has_right;
    logic   has_below;
  } in_item_t;

  typedef struct packed {
    sample_t luma_top_left;
    sample_t luma_top_right;
    sample_t luma_bottom_left;
    sample_t luma_bottom_right;
    sample_t chroma_u;
    sample_t chroma_v;
  } out_item_t;

  // BT.601 limited-range coefficients, scaled by 256
  localparam logic [15:0] Y_R = 16'd66;
  localparam logic [15:0] Y_G = 16'd129;
  localparam logic [15:0] Y_B = 16'd25;
  localparam logic [15:0] RND = 16'd128;
  localparam logic [7:0]  Y_OFS = 8'd16;

  // chroma magnitudes; signs are applied in the datapath
  localparam logic [15:0] U_R = 16'd38;
  localparam logic [15:0] U_G = 16'd74;
  localparam logic [15:0] U_B = 16'd112;
  localparam logic [15:0] V_R = 16'd112;
  localparam logic [15:0] V_G = 16'd94;
  localparam logic [15:0] V_B = 16'd18;
  // rounding plus 128 offset in the upper byte keeps the sum positive
  localparam logic [15:0] C_BIAS = 16'd32896;

  localparam logic ORDER_RGBA = 1'b0;
  localparam logic ORDER_BGRA = 1'b1;

endpackage

FILE: rtl/ryuv_if.sv
// Valid/ready channel interface used by the RGB to YUV 4:2:0 block unit.
// Payload type comes in as a type parameter (see ryuv_pkg).
interface ryuv_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/rgb_to_yuv420_block_unit.sv
// RGB to YUV 4:2:0 block unit: one 2x2 pixel block in, four lumas and one U/V out.
// Each accepted block is registered in s1, then its result in res, which drives yuv.
// Throughput: one block per cycle unless yuv.ready stalls; all math is constant-coefficient
// shift-add logic between the two registers.
// Reset (rst, synchronous): empties both stages and sets source_order to RGBA.
// Depends on ryuv_pkg, ryuv_if and rgb_to_yuv420_block_unit_assert.svh.
module rgb_to_yuv420_block_unit (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_write,
  input  logic  cfg_data,
  ryuv_if.sink   pixels,
  ryuv_if.source yuv
);
  import ryuv_pkg::*;

  `include "rgb_to_yuv420_block_unit_assert.svh"

  function automatic sample_t luma_of(input sample_t r, input sample_t g, input sample_t b);
    logic [15:0] acc;
    acc = 16'(r) * Y_R + 16'(g) * Y_G + 16'(b) * Y_B + RND;
    return acc[15:8] + Y_OFS;
  endfunction

  function automatic sample_t red_of(input pixel_t px, input logic order);
    return (order == ORDER_BGRA) ? px[23:16] : px[7:0];
  endfunction

  function automatic sample_t blue_of(input pixel_t px, input logic order);
    return (order == ORDER_BGRA) ? px[7:0] : px[23:16];
  endfunction

  logic      source_order;
  logic      s1_valid;
  in_item_t  s1;
  logic      res_valid;
  out_item_t res;
  out_item_t res_next;

  logic adv_in;
  logic adv_out;

  // handshake: each stage advances when the one after it has room
  assign adv_out      = !res_valid || yuv.ready;
  assign adv_in       = !s1_valid || adv_out;
  assign pixels.ready = adv_in;
  assign yuv.valid    = res_valid;
  assign yuv.data     = res;

  // datapath between input register and result register
  logic                pr, pb, pbr;
  sample_t [3:0]       r, g, b;
  pixel_t  [3:0]       px;
  logic    [9:0]       sr, sg, sb;
  logic    [1:0]       shift;
  logic    [9:0]       mr_w, mg_w, mb_w;
  sample_t             mr, mg, mb;
  logic    [15:0]      xu, xv;

  assign pr  = s1.has_right;
  assign pb  = s1.has_below;
  assign pbr = pr && pb;
  assign px  = {s1.pixel_bottom_right, s1.pixel_bottom_left,
                s1.pixel_top_right, s1.pixel_top_left};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      r[i] = red_of(px[i], source_order);
      g[i] = px[i][15:8];
      b[i] = blue_of(px[i], source_order);
    end
  end

  // absent pixels drop out of the sums
  assign sr = 10'(r[0]) + (pr ? 10'(r[1]) : 10'd0) + (pb ? 10'(r[2]) : 10'd0)
            + (pbr ? 10'(r[3]) : 10'd0);
  assign sg = 10'(g[0]) + (pr ? 10'(g[1]) : 10'd0) + (pb ? 10'(g[2]) : 10'd0)
            + (pbr ? 10'(g[3]) : 10'd0);
  assign sb = 10'(b[0]) + (pr ? 10'(b[1]) : 10'd0) + (pb ? 10'(b[2]) : 10'd0)
            + (pbr ? 10'(b[3]) : 10'd0);

  // count is 1, 2 or 4, so the mean is a shift by 0, 1 or 2
  assign shift = {1'b0, pr} + {1'b0, pb};
  assign mr_w  = sr >> shift;
  assign mg_w  = sg >> shift;
  assign mb_w  = sb >> shift;
  assign mr    = mr_w[7:0];
  assign mg    = mg_w[7:0];
  assign mb    = mb_w[7:0];

  // the result never leaves 16 bits, so wraparound in the middle is harmless
  assign xu = 16'(mb) * U_B + C_BIAS - 16'(mr) * U_R - 16'(mg) * U_G;
  assign xv = 16'(mr) * V_R + C_BIAS - 16'(mg) * V_G - 16'(mb) * V_B;

  always_comb begin
    res_next.luma_top_left     = luma_of(r[0], g[0], b[0]);
    res_next.luma_top_right    = pr  ? luma_of(r[1], g[1], b[1]) : '0;
    res_next.luma_bottom_left  = pb  ? luma_of(r[2], g[2], b[2]) : '0;
    res_next.luma_bottom_right = pbr ? luma_of(r[3], g[3], b[3]) : '0;
    res_next.chroma_u          = xu[15:8];
    res_next.chroma_v          = xv[15:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_order <= ORDER_RGBA;
      s1_valid     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        source_order <= cfg_data;
      end
      if (adv_in) begin
        s1_valid <= pixels.valid;
      end
      if (adv_out) begin
        res_valid <= s1_valid;
      end
    end
  end

  // payload registers: load on advance, hold otherwise
  always_ff @(posedge clk) begin
    if (adv_in && pixels.valid) begin
      s1 <= pixels.data;
    end
    if (adv_out && s1_valid) begin
      res <= res_next;
    end
  end

  `RYUV_ASSERT_NEXT(a_stage_moves, clk, rst, s1_valid && adv_out, res_valid)
  `RYUV_ASSERT_NOW(a_full_stall_blocks_input, clk, rst,
                   s1_valid && res_valid && !yuv.ready, !pixels.ready)
  `RYUV_ASSERT_NOW(a_result_range, clk, rst, res_valid,
                   res.luma_top_left >= 8'd16 && res.luma_top_left <= 8'd235 &&
                   res.chroma_u >= 8'd16 && res.chroma_u <= 8'd240 &&
                   res.chroma_v >= 8'd16 && res.chroma_v <= 8'd240)

endmodule

FILE: dv/rgb_to_yuv420_block_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for rgb_to_yuv420_block_unit: 2x2 pixel blocks in, predicted lumas and U/V checked.
// Depends on ryuv_pkg, ryuv_if and the block itself; self-checking, no files read.
module rgb_to_yuv420_block_unit_tb;
  import ryuv_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int END_SETTLE  = 10;
  localparam int PHASE_ITEMS = 200;

  logic clk;
  logic rst;
  logic cfg_write;
  logic cfg_data;

  ryuv_if #(.payload_t(in_item_t))  pixels_if ();
  ryuv_if #(.payload_t(out_item_t)) yuv_if ();

  rgb_to_yuv420_block_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .pixels    (pixels_if.sink),
    .yuv       (yuv_if.source)
  );

  out_item_t pending_yuv[$];
  logic      tb_order;
  bit        src_idle;
  bit        snk_idle;
  int        errors;
  int        blocks_sent;
  int        results_checked;
  int        cfg_writes;
  int        idle_cycles;

  always #5 clk = ~clk;

  // Predicted result of one block under the given byte order.
  function automatic out_item_t convert_block(in_item_t blk, logic order);
    out_item_t res;
    pixel_t    px[4];
    bit        present[4];
    int        r, g, b, sr, sg, sb, shift, mr, mg, mb, xu, xv, i;
    sample_t   luma[4];
    px[0] = blk.pixel_top_left;
    px[1] = blk.pixel_top_right;
    px[2] = blk.pixel_bottom_left;
    px[3] = blk.pixel_bottom_right;
    present[0] = 1'b1;
    present[1] = blk.has_right;
    present[2] = blk.has_below;
    present[3] = blk.has_right && blk.has_below;
    sr = 0;
    sg = 0;
    sb = 0;
    for (i = 0; i < 4; i++) begin
      r = (order == ORDER_BGRA) ? int'(px[i][23:16]) : int'(px[i][7:0]);
      g = int'(px[i][15:8]);
      b = (order == ORDER_BGRA) ? int'(px[i][7:0]) : int'(px[i][23:16]);
      if (present[i]) begin
        luma[i] = 8'(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
        sr += r;
        sg += g;
        sb += b;
      end else begin
        luma[i] = 8'd0;
      end
    end
    shift = int'(blk.has_right) + int'(blk.has_below);
    mr = sr >> shift;
    mg = sg >> shift;
    mb = sb >> shift;
    // bias of 32768 keeps the sums positive, so the shift floors
    xu = -38 * mr - 74 * mg + 112 * mb + 128 + 32768;
    xv = 112 * mr - 94 * mg - 18 * mb + 128 + 32768;
    res.luma_top_left     = luma[0];
    res.luma_top_right    = luma[1];
    res.luma_bottom_left  = luma[2];
    res.luma_bottom_right = luma[3];
    res.chroma_u          = 8'(xu >>> 8);
    res.chroma_v          = 8'(xv >>> 8);
    return res;
  endfunction

  function automatic in_item_t make_block(pixel_t tl, pixel_t tr, pixel_t bl, pixel_t br,
                                          logic right, logic below);
    in_item_t blk;
    blk.pixel_top_left     = tl;
    blk.pixel_top_right    = tr;
    blk.pixel_bottom_left  = bl;
    blk.pixel_bottom_right = br;
    blk.has_right          = right;
    blk.has_below          = below;
    return blk;
  endfunction

  // Mostly full random pixels, some with every byte at 0x00 or 0xFF.
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int     i;
    p = pixel_t'($urandom);
    if ($urandom_range(7, 0) == 0) begin
      for (i = 0; i < 3; i++) p[8*i +: 8] = $urandom_range(1, 0) ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic check_field(string what, sample_t got, sample_t want);
    if (got !== want) report_mismatch(what, int'(got), int'(want));
  endtask

  // Send one item; valid stays high after acceptance so back-to-back items need no gap.
  task automatic push_block(in_item_t blk);
    int gap;
    gap = src_idle ? $urandom_range(9, 0) : 0;
    repeat (gap) begin
      @(negedge clk);
      pixels_if.valid = 1'b0;
    end
    @(negedge clk);
    pixels_if.valid = 1'b1;
    pixels_if.data  = blk;
    do @(posedge clk); while (!pixels_if.ready);
    pending_yuv.push_back(convert_block(blk, tb_order));
    blocks_sent++;
  endtask

  // Drop valid before the next edge, then hold until every result is back.
  task automatic wait_drained();
    @(negedge clk);
    pixels_if.valid = 1'b0;
    while (pending_yuv.size() != 0) @(posedge clk);
  endtask

  task automatic write_order(logic order);
    wait_drained();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data  = order;
    @(negedge clk);
    cfg_write = 1'b0;
    tb_order  = order;
    cfg_writes++;
  endtask

  task automatic test_directed_rgba();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    write_order(ORDER_RGBA);
    push_block(make_block(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b1));
    push_block(make_block(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1));
    // single present pixel, absent ones hold garbage
    push_block(make_block(24'h0000FF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0));
    push_block(make_block(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0));
    push_block(make_block(24'h00FF00, 24'h0000FF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0));
    push_block(make_block(24'hFF0000, 24'hAAAAAA, 24'h00FF00, 24'h555555, 1'b0, 1'b1));
    push_block(make_block(24'hFFFFFF, 24'h123456, 24'h000000, 24'hABCDEF, 1'b0, 1'b1));
    push_block(make_block(24'h0000FF, 24'h00FF00, 24'hFF0000, 24'hFFFFFF, 1'b1, 1'b1));
    push_block(make_block(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 1'b1, 1'b1));
    // sums that do not divide evenly: mean truncates
    push_block(make_block(24'h010203, 24'h020304, 24'h000000, 24'h000001, 1'b1, 1'b1));
    push_block(make_block(24'h0000FF, 24'h0000FE, 24'h000000, 24'h000000, 1'b1, 1'b0));
  endtask

  task automatic test_directed_bgra();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    write_order(ORDER_BGRA);
    push_block(make_block(24'hFF0000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0));
    push_block(make_block(24'h0000FF, 24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b0));
    push_block(make_block(24'h00FF00, 24'hFF0000, 24'h000000, 24'h000000, 1'b1, 1'b0));
    push_block(make_block(24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF, 1'b1, 1'b1));
    push_block(make_block(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b1));
    push_block(make_block(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1));
    push_block(make_block(24'h030201, 24'h000000, 24'h040302, 24'h000000, 1'b0, 1'b1));
  endtask

  task automatic test_random_phase(logic order, bit s_idle, bit k_idle, bit pause_mid);
    int n;
    write_order(order);
    src_idle = s_idle;
    snk_idle = k_idle;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      // sender holds off until the pipe is empty, then resumes
      if (pause_mid && n == PHASE_ITEMS / 2) wait_drained();
      push_block(make_block(rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel(),
                            1'($urandom_range(1, 0)), 1'($urandom_range(1, 0))));
    end
  endtask

  // Result side: random stall per item when snk_idle is set, check each accepted item against the oldest prediction.
  initial begin : yuv_sink
    int        stall;
    out_item_t got;
    out_item_t want;
    yuv_if.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = snk_idle ? $urandom_range(9, 0) : 0;
      repeat (stall) begin
        @(negedge clk);
        yuv_if.ready = 1'b0;
      end
      @(negedge clk);
      yuv_if.ready = 1'b1;
      do @(posedge clk); while (!yuv_if.valid);
      got = yuv_if.data;
      if (pending_yuv.size() == 0) begin
        report_mismatch("result with no block pending", int'(got.chroma_u), 0);
      end else begin
        want = pending_yuv.pop_front();
        check_field("luma_top_left", got.luma_top_left, want.luma_top_left);
        check_field("luma_top_right", got.luma_top_right, want.luma_top_right);
        check_field("luma_bottom_left", got.luma_bottom_left, want.luma_bottom_left);
        check_field("luma_bottom_right", got.luma_bottom_right, want.luma_bottom_right);
        check_field("chroma_u", got.chroma_u, want.chroma_u);
        check_field("chroma_v", got.chroma_v, want.chroma_v);
        results_checked++;
      end
    end
  end

  // Stop the run when no item moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (pixels_if.valid && pixels_if.ready) || (yuv_if.valid && yuv_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_data        = ORDER_RGBA;
    pixels_if.valid = 1'b0;
    pixels_if.data  = '0;
    tb_order        = ORDER_RGBA;
    src_idle        = 1'b0;
    snk_idle        = 1'b0;
    errors          = 0;
    blocks_sent     = 0;
    results_checked = 0;
    cfg_writes      = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_directed_rgba();
    test_directed_bgra();
    test_random_phase(ORDER_RGBA, 1'b1, 1'b1, 1'b0);
    test_random_phase(ORDER_BGRA, 1'b0, 1'b0, 1'b1);
    test_random_phase(ORDER_BGRA, 1'b1, 1'b0, 1'b0);
    test_random_phase(ORDER_RGBA, 1'b0, 1'b1, 1'b0);
    test_random_phase(ORDER_BGRA, 1'b1, 1'b1, 1'b1);

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (pending_yuv.size() != 0) report_mismatch("results missing", pending_yuv.size(), 0);

    $display("covered %0d blocks with 1, 2 and 4 present pixels, %0d results checked,",
             blocks_sent, results_checked);
    $display("%0d byte order writes across RGBA and BGRA, with and without handshake idling",
             cfg_writes);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
